[src/bpe_pkg.sv]
// Shared types, constants and scale table for the Bernstein palette entry unit.
package bpe_pkg;

  // Field and datapath widths fixed by the interface
  localparam int IDX_W       = 12;
  localparam int ENTRY_W     = 13;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 24;
  localparam int SCALE_W     = 13;
  localparam int MODE_W      = 2;
  localparam int STEP_W      = 3;
  localparam int CH_W        = 2;

  // Default table size and reset entry count
  localparam int DEF_MAX_ENTRIES = 4096;
  localparam logic [ENTRY_W-1:0] ENTRY_RESET = 13'd256;

  // Sequencer step counts
  localparam int POW_STEPS = 3;
  localparam int DIV_STEPS = CHAN_W;

  // Palette modes
  localparam logic [MODE_W-1:0] MODE_WARM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GREEN = 2'd2;

  // Channel codes, in computation order
  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NPOW,
    ST_POLY,
    ST_SCALE,
    ST_DIV,
    ST_FIN
  } bpe_state_e;

  // Shared unit operations
  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MUL_FIRST,
    ALU_MUL,
    ALU_SCALE,
    ALU_DIV
  } bpe_alu_op_e;

  // Control from the sequencer to the shared unit
  typedef struct packed {
    bpe_alu_op_e op;
    logic        save_n4;
    logic        dbl_div;
  } bpe_alu_ctrl_t;

  // Channel scale times polynomial coefficient; blue carries 17 over a doubled divisor
  function automatic logic [SCALE_W-1:0] scale_k(input logic [MODE_W-1:0] mode,
                                                 input logic [CH_W-1:0]   ch);
    logic [SCALE_W-1:0] k;
    k = '0;
    case (mode)
      MODE_GRAY: begin
        case (ch)
          CH_RED:   k = 13'd2295;
          CH_GREEN: k = 13'd3825;
          default:  k = 13'd4335;
        endcase
      end
      MODE_GREEN: begin
        case (ch)
          CH_RED:   k = 13'd225;
          CH_GREEN: k = 13'd3825;
          default:  k = 13'd425;
        endcase
      end
      default: begin
        case (ch)
          CH_RED:   k = 13'd2295;
          CH_GREEN: k = 13'd375;
          default:  k = 13'd2635;
        endcase
      end
    endcase
    return k;
  endfunction

endpackage

[src/bernstein_palette_entry_unit.sv]
// Top level of the Bernstein palette entry unit: sequencer, mode and output register.
//
// Turns one palette index into a packed 24-bit color from Bernstein polynomials of
// t = index / entry_count, scaled per palette mode. Each item is worked through one
// shared multiplier and a restoring divider: n^4 first, then per channel the
// polynomial products, one scale multiply and eight quotient-bit steps. The input
// stays not ready while an item is in flight, so a new request is taken only once
// the last color is loaded into the output register; that register lets a finished
// color wait while the next request is taken. An entry_count of zero acts as one,
// counts above MAX_ENTRIES saturate, and an index at or past the count gives black.
// The entry count is sampled when a request is accepted, so a write to entry_count
// applies to requests accepted after it. The palette mode steps through its three
// settings after each request marked end_of_palette.
module bernstein_palette_entry_unit
  import bpe_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [ENTRY_W-1:0] cfg_wdata_i,
  // request
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IDX_W-1:0]   index_i,
  input  logic               end_of_palette_i,
  // result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] color_o
);

  localparam int NW = $clog2(MAX_ENTRIES+1);
  localparam int OW = (NW > SCALE_W) ? NW : SCALE_W;
  localparam int EW = (NW > ENTRY_W) ? NW : ENTRY_W;
  localparam int CW = (NW > IDX_W) ? NW : IDX_W;

  bpe_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CH_W-1:0]   ch_q, ch_d;

  logic [ENTRY_W-1:0] entry_count_q;
  logic [MODE_W-1:0]  palette_mode_q;
  logic               out_valid_q;
  logic               cap_q;

  logic [NW-1:0]      n_q, i_q, m_q;
  logic               last_q;
  logic [2*CHAN_W-1:0] chan_q;
  logic [COLOR_W-1:0] color_q;

  logic [EW-1:0] ec_ext, n_sel;
  logic [NW-1:0] n_new, i_new;
  logic          idx_in_range;
  logic          accept, load_out;
  logic          pow_last, div_last;

  bpe_alu_ctrl_t     alu_ctrl;
  logic [NW-1:0]     alu_a;
  logic [OW-1:0]     alu_b;
  logic [CHAN_W-1:0] alu_q;
  logic [COLOR_W-1:0] color_new;

  // Clamp entry count to 1..MAX_ENTRIES; out-of-range index reads as zero
  assign ec_ext = EW'(entry_count_q);
  always_comb begin
    if (ec_ext == '0) begin
      n_sel = EW'(1);
    end else if (ec_ext > EW'(MAX_ENTRIES)) begin
      n_sel = EW'(MAX_ENTRIES);
    end else begin
      n_sel = ec_ext;
    end
  end
  assign n_new        = n_sel[NW-1:0];
  assign idx_in_range = CW'(index_i) < CW'(n_new);
  assign i_new        = idx_in_range ? NW'(index_i) : '0;

  assign accept   = in_valid_i && in_ready_o;
  assign pow_last = (step_q == STEP_W'(POW_STEPS-1));
  assign div_last = (step_q == STEP_W'(DIV_STEPS-1));

  // Next state and counters
  always_comb begin
    state_d = state_q;
    step_d  = step_q + STEP_W'(1);
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = ST_NPOW;
          ch_d    = CH_RED;
        end
      end
      ST_NPOW: begin
        if (pow_last) begin
          state_d = ST_POLY;
          step_d  = '0;
        end
      end
      ST_POLY: begin
        if (pow_last) begin
          state_d = ST_SCALE;
          step_d  = '0;
        end
      end
      ST_SCALE: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        if (div_last) begin
          step_d = '0;
          if (ch_q == CH_BLUE) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_POLY;
            ch_d    = ch_q + CH_W'(1);
          end
        end
      end
      ST_FIN: begin
        step_d = '0;
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: operands and op for the shared unit
  always_comb begin
    in_ready_o       = 1'b0;
    load_out         = 1'b0;
    alu_ctrl.op      = ALU_NOP;
    alu_ctrl.save_n4 = 1'b0;
    alu_ctrl.dbl_div = (ch_q == CH_BLUE);
    alu_a            = n_q;
    alu_b            = OW'(n_q);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_NPOW: begin
        alu_ctrl.op      = (step_q == '0) ? ALU_MUL_FIRST : ALU_MUL;
        alu_ctrl.save_n4 = pow_last;
      end
      ST_POLY: begin
        // red i*i*i*m, green i*i*m*m, blue m*m*m*i
        alu_a = (ch_q == CH_BLUE) ? m_q : i_q;
        case (step_q)
          STEP_W'(0): begin
            alu_ctrl.op = ALU_MUL_FIRST;
            alu_b       = OW'(alu_a);
          end
          STEP_W'(1): begin
            alu_ctrl.op = ALU_MUL;
            alu_b       = (ch_q == CH_RED) ? OW'(i_q) : OW'(m_q);
          end
          default: begin
            alu_ctrl.op = ALU_MUL;
            alu_b       = (ch_q == CH_BLUE) ? OW'(i_q) : OW'(m_q);
          end
        endcase
      end
      ST_SCALE: begin
        alu_ctrl.op = ALU_SCALE;
        alu_b       = OW'(scale_k(palette_mode_q, ch_q));
      end
      ST_DIV: begin
        alu_ctrl.op = ALU_DIV;
      end
      ST_FIN: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  bpe_alu #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_alu (
    .clk_i (clk_i),
    .ctrl_i(alu_ctrl),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .q_o   (alu_q)
  );

  // Pack channels; blue comes straight from the divider
  always_comb begin
    if (palette_mode_q == MODE_GREEN) begin
      color_new = {alu_q, chan_q[CHAN_W-1:0], chan_q[2*CHAN_W-1:CHAN_W]};
    end else begin
      color_new = {chan_q, alu_q};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= '0;
      ch_q           <= CH_RED;
      entry_count_q  <= ENTRY_RESET;
      palette_mode_q <= MODE_WARM;
      out_valid_q    <= 1'b0;
      cap_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ch_q    <= ch_d;
      cap_q   <= (state_q == ST_DIV) && div_last;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          palette_mode_q <= (palette_mode_q >= MODE_GREEN) ? MODE_WARM
                                                           : palette_mode_q + MODE_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q    <= n_new;
      i_q    <= i_new;
      m_q    <= n_new - i_new;
      last_q <= end_of_palette_i;
    end
    if (cap_q && state_q != ST_FIN) begin
      chan_q <= {chan_q[CHAN_W-1:0], alu_q};
    end
    if (load_out) begin
      color_q <= color_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign color_o     = color_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_NPOW) && (step_q == '0) && (ch_q == CH_RED))
    else $error("accepted request did not start n^4 sequence");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside finish state");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    palette_mode_q != MODE_W'(3))
    else $error("palette mode left its three settings");

  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> ch_q != CH_W'(3))
    else $error("channel counter out of range");

  a_pow_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NPOW || state_q == ST_POLY) |-> step_q < STEP_W'(POW_STEPS))
    else $error("product step counter overran");

endmodule

[src/bpe_alu.sv]
// Shared multiplier and restoring divider used by the palette sequencer.
module bpe_alu
  import bpe_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                     clk_i,
  input  bpe_alu_ctrl_t            ctrl_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0] a_i,
  input  logic [((($clog2(MAX_ENTRIES+1)) > SCALE_W) ?
                 $clog2(MAX_ENTRIES+1) : SCALE_W)-1:0] b_i,
  output logic [CHAN_W-1:0]        q_o
);

  localparam int NW = $clog2(MAX_ENTRIES+1);
  localparam int OW = (NW > SCALE_W) ? NW : SCALE_W;
  localparam int PW = 4 * NW;          // holds n^4 and every polynomial product
  localparam int XW = PW + SCALE_W;    // scaled numerator / remainder
  localparam int DW = PW + 1 + DIV_STEPS - 1;  // divisor shifted to the top quotient bit

  logic [XW-1:0]     acc_q;
  logic [PW-1:0]     n4_q;
  logic [DW-1:0]     dsh_q;
  logic [CHAN_W-1:0] q_q;

  logic [PW-1:0]    mul_a;
  logic [PW+OW-1:0] prod;
  logic [PW:0]      div_d;
  logic [XW-1:0]    dsh_ext;
  logic             ge;

  // One multiplier: first factor from the port or the running product
  assign mul_a = (ctrl_i.op == ALU_MUL_FIRST) ? PW'(a_i) : acc_q[PW-1:0];
  assign prod  = PW'(mul_a) * (PW+OW)'(b_i);

  // Divisor is n^4, doubled for blue
  assign div_d   = ctrl_i.dbl_div ? {n4_q, 1'b0} : {1'b0, n4_q};
  assign dsh_ext = XW'(dsh_q);
  assign ge      = (acc_q >= dsh_ext);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      ALU_MUL_FIRST, ALU_MUL: begin
        acc_q <= prod[XW-1:0];
        if (ctrl_i.save_n4) begin
          n4_q <= prod[PW-1:0];
        end
      end
      ALU_SCALE: begin
        acc_q <= prod[XW-1:0];
        dsh_q <= {div_d, (DIV_STEPS-1)'(0)};
        q_q   <= '0;
      end
      ALU_DIV: begin
        if (ge) begin
          acc_q <= acc_q - dsh_ext;
        end
        dsh_q <= dsh_q >> 1;
        q_q   <= {q_q[CHAN_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign q_o = q_q;

endmodule
